### rtl/core/llagp_pkg.sv
// ----------------------------------------------------------------------------
// llagp_pkg
// Shared types, constants and elaboration-time table functions for the
// latitude/longitude/altitude to Cartesian point pipeline.
// ----------------------------------------------------------------------------
package llagp_pkg;

    // field widths
    localparam int LAT_W    = 16;
    localparam int LON_W    = 17;
    localparam int ALT_W    = 16;
    localparam int RADIUS_W = 24;
    localparam int R_W      = 26;   // signed radius after altitude term
    localparam int ANGLE_W  = 32;   // Q24 degrees after folding
    localparam int WRAP_W   = 35;   // Q24 degrees before wrapping
    localparam int TRIG_W   = 32;   // Q30 sine and cosine
    localparam int POINT_W  = 26;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 80;

    // Q24 degree constants
    localparam logic signed [WRAP_W-1:0] ANG_90  = 35'sd1509949440;
    localparam logic signed [WRAP_W-1:0] ANG_180 = 35'sd3019898880;
    localparam logic signed [WRAP_W-1:0] ANG_360 = 35'sd6039797760;

    // altitude term: round(alt * 65536 / 275000) = floor((|alt|*2^14 + 34375) / 68750)
    localparam int ALT_NUM_W   = 30;
    localparam int ALT_PROD_W  = 61;
    localparam int ALT_Q_W     = 13;
    localparam logic [63:0] ALT_DIV   = 64'd68750;
    localparam logic [63:0] ALT_BIAS  = 64'd34375;
    localparam int          ALT_SHIFT = 47;
    localparam logic [30:0] ALT_RECIP =
        31'(((64'd1 << ALT_SHIFT) + ALT_DIV - 64'd1) / ALT_DIV);

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam int TABLE_LOOPS = 32;

    // stage payload from the front end into the rotator
    typedef struct packed {
        logic signed [ANGLE_W-1:0] z_lat;
        logic                      neg_lat;
        logic signed [ANGLE_W-1:0] z_lon;
        logic                      neg_lon;
        logic signed [R_W-1:0]     radius;
    } angle_item_t;

    // stage payload from the rotator into the product stages
    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_lat;
        logic signed [TRIG_W-1:0] cos_lat;
        logic signed [TRIG_W-1:0] sin_lon;
        logic signed [TRIG_W-1:0] cos_lon;
        logic signed [R_W-1:0]    radius;
    } trig_item_t;

    // one result point
    typedef struct packed {
        logic signed [POINT_W-1:0] z;
        logic signed [POINT_W-1:0] y;
        logic signed [POINT_W-1:0] x;
    } point_t;

    // unsigned restoring division for the table functions
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        int          i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            quo = quo << 1;
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // arctangent of 2^-idx in Q24 degrees, rounded
    function automatic logic [63:0] atan_q24(input int idx);
        logic [63:0] sum;
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] term;
        int          e;
        int          k;
        sum = '0;
        q   = '0;
        if (idx == 0)
        begin
            return 64'd45 << 24;
        end
        // series for atan in Q62
        for (k = 0; k < TABLE_LOOPS; k++)
        begin
            e = 62 - idx * (2 * k + 1);
            if (e >= 0)
            begin
                term = udiv64(64'd1 << e, 64'(2 * k + 1));
                if ((k & 1) == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
        end
        // long division by pi gives radians / pi in Q40 steps
        rem = sum;
        for (k = 0; k < 40; k++)
        begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= PI_Q60)
            begin
                rem  = rem - PI_Q60;
                q[0] = 1'b1;
            end
        end
        return (64'd45 * q + (64'd1 << 15)) >> 16;
    endfunction

    // inverse rotator gain in Q30 for a given step count
    function automatic logic [63:0] gain_inv_q30(input int steps);
        logic [63:0] g2;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] g;
        int          i;
        g2 = 64'd1 << 60;
        for (i = 0; i < TABLE_LOOPS; i++)
        begin
            if (i < steps && 2 * i < 61)
            begin
                g2 = g2 + (g2 >> (2 * i));
            end
        end
        // integer square root
        v    = g2;
        res  = '0;
        bitv = 64'd1 << 62;
        for (i = 0; i < TABLE_LOOPS; i++)
        begin
            if (bitv > v)
            begin
                bitv = bitv >> 2;
            end
        end
        for (i = 0; i < TABLE_LOOPS; i++)
        begin
            if (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        g = res;
        return udiv64((64'd1 << 60) + (g >> 1), g);
    endfunction

endpackage

### rtl/core/llagp_front.sv
// ----------------------------------------------------------------------------
// llagp_front
// Input register, radius computation and angle wrap/fold, four stages.
// ----------------------------------------------------------------------------
module llagp_front
    import llagp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic signed [LAT_W-1:0]  latitude,
    input  logic signed [LON_W-1:0]  longitude,
    input  logic signed [ALT_W-1:0]  altitude,
    input  logic [RADIUS_W-1:0]      sphere_radius,
    output logic                     out_valid,
    output angle_item_t              out_item
);

    // stage 0: input register
    logic                     v0_reg;
    logic signed [LAT_W-1:0]  lat0_reg;
    logic signed [LON_W-1:0]  lon0_reg;
    logic signed [ALT_W-1:0]  alt0_reg;

    // stage 1: altitude numerator, wrapped angles
    logic                        v1_reg;
    logic [ALT_NUM_W-1:0]        num1_reg;
    logic                        aneg1_reg;
    logic signed [WRAP_W-1:0]    zlat1_reg;
    logic signed [WRAP_W-1:0]    zlon1_reg;

    // stage 2: reciprocal product, folded angles
    logic                        v2_reg;
    logic [ALT_PROD_W-1:0]       prod2_reg;
    logic                        aneg2_reg;
    logic signed [ANGLE_W-1:0]   zlat2_reg;
    logic signed [ANGLE_W-1:0]   zlon2_reg;
    logic                        nlat2_reg;
    logic                        nlon2_reg;

    // stage 3: radius
    logic                        v3_reg;
    angle_item_t                 item3_reg;

    logic [ALT_W-1:0]            alt_abs;
    logic [ALT_NUM_W-1:0]        num_next;
    logic signed [WRAP_W-1:0]    zlat_raw;
    logic signed [WRAP_W-1:0]    zlon_raw;
    logic signed [WRAP_W-1:0]    zlat_wrap;
    logic signed [WRAP_W-1:0]    zlon_wrap;
    logic signed [WRAP_W-1:0]    zlat_fold;
    logic signed [WRAP_W-1:0]    zlon_fold;
    logic                        nlat_fold;
    logic                        nlon_fold;
    logic [ALT_Q_W-1:0]          alt_q;
    logic signed [ALT_Q_W:0]     adj;
    logic signed [R_W-1:0]       radius_next;

    // wrap into [-180, 180)
    function automatic logic signed [WRAP_W-1:0] wrap_deg(input logic signed [WRAP_W-1:0] z);
        logic signed [WRAP_W-1:0] w;
        w = z;
        priority if (w >= ANG_180)
        begin
            w = w - ANG_360;
        end
        else if (w < -ANG_180)
        begin
            w = w + ANG_360;
        end
        return w;
    endfunction

    // stage 1 logic
    always_comb
    begin
        alt_abs   = alt0_reg[ALT_W-1] ? (~alt0_reg + 1'b1) : alt0_reg;
        num_next  = {alt_abs, 14'b0} + ALT_NUM_W'(ALT_BIAS);
        zlat_raw  = {{(WRAP_W - LAT_W - 16){lat0_reg[LAT_W-1]}}, lat0_reg, 16'b0};
        zlon_raw  = {{(WRAP_W - LON_W - 16){lon0_reg[LON_W-1]}}, lon0_reg, 16'b0};
        zlat_wrap = wrap_deg(zlat_raw);
        zlon_wrap = wrap_deg(zlon_raw);
    end

    // stage 2 logic: fold beyond +-90 by 180 degrees
    always_comb
    begin
        zlat_fold = zlat1_reg;
        nlat_fold = 1'b0;
        priority if (zlat1_reg > ANG_90)
        begin
            zlat_fold = zlat1_reg - ANG_180;
            nlat_fold = 1'b1;
        end
        else if (zlat1_reg < -ANG_90)
        begin
            zlat_fold = zlat1_reg + ANG_180;
            nlat_fold = 1'b1;
        end
        zlon_fold = zlon1_reg;
        nlon_fold = 1'b0;
        priority if (zlon1_reg > ANG_90)
        begin
            zlon_fold = zlon1_reg - ANG_180;
            nlon_fold = 1'b1;
        end
        else if (zlon1_reg < -ANG_90)
        begin
            zlon_fold = zlon1_reg + ANG_180;
            nlon_fold = 1'b1;
        end
    end

    // stage 3 logic: quotient, sign, radius sum
    always_comb
    begin
        alt_q       = prod2_reg[ALT_SHIFT+ALT_Q_W-1:ALT_SHIFT];
        adj         = aneg2_reg ? -$signed({1'b0, alt_q}) : $signed({1'b0, alt_q});
        radius_next = $signed({{(R_W - RADIUS_W){1'b0}}, sphere_radius})
                    + {{(R_W - ALT_Q_W - 1){adj[ALT_Q_W]}}, adj};
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lat0_reg  <= latitude;
            lon0_reg  <= longitude;
            alt0_reg  <= altitude;

            num1_reg  <= num_next;
            aneg1_reg <= alt0_reg[ALT_W-1];
            zlat1_reg <= zlat_wrap;
            zlon1_reg <= zlon_wrap;

            prod2_reg <= num1_reg * ALT_RECIP;
            aneg2_reg <= aneg1_reg;
            zlat2_reg <= zlat_fold[ANGLE_W-1:0];
            zlon2_reg <= zlon_fold[ANGLE_W-1:0];
            nlat2_reg <= nlat_fold;
            nlon2_reg <= nlon_fold;

            item3_reg.z_lat   <= zlat2_reg;
            item3_reg.neg_lat <= nlat2_reg;
            item3_reg.z_lon   <= zlon2_reg;
            item3_reg.neg_lon <= nlon2_reg;
            item3_reg.radius  <= radius_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

### rtl/core/llagp_cordic.sv
// ----------------------------------------------------------------------------
// llagp_cordic
// Two-lane rotation CORDIC in degrees, one step per stage, then sign fix.
// ----------------------------------------------------------------------------
module llagp_cordic
    import llagp_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  angle_item_t in_item,
    output logic        out_valid,
    output trig_item_t  out_item
);

    localparam logic signed [TRIG_W-1:0] GAIN = TRIG_W'(gain_inv_q30(CORDIC_STEPS));

    typedef struct packed {
        logic signed [TRIG_W-1:0]  x;
        logic signed [TRIG_W-1:0]  y;
        logic signed [ANGLE_W-1:0] z;
    } rot_t;

    // one micro-rotation
    function automatic rot_t rotate(input rot_t v, input int sh,
                                    input logic signed [ANGLE_W-1:0] ang);
        rot_t r;
        if (v.z >= 0)
        begin
            r.x = v.x - (v.y >>> sh);
            r.y = v.y + (v.x >>> sh);
            r.z = v.z - ang;
        end
        else
        begin
            r.x = v.x + (v.y >>> sh);
            r.y = v.y - (v.x >>> sh);
            r.z = v.z + ang;
        end
        return r;
    endfunction

    rot_t                  lat_reg    [CORDIC_STEPS];
    rot_t                  lon_reg    [CORDIC_STEPS];
    logic                  nlat_reg   [CORDIC_STEPS];
    logic                  nlon_reg   [CORDIC_STEPS];
    logic signed [R_W-1:0] radius_reg [CORDIC_STEPS];
    logic                  valid_reg  [CORDIC_STEPS];

    logic                  out_valid_reg;
    trig_item_t            out_item_reg;

    for (genvar s = 0; s < CORDIC_STEPS; s++)
    begin : g_stage
        localparam logic signed [ANGLE_W-1:0] ATAN = ANGLE_W'(atan_q24(s));

        rot_t                  lat_in;
        rot_t                  lon_in;
        logic                  nlat_in;
        logic                  nlon_in;
        logic signed [R_W-1:0] radius_in;
        logic                  valid_in;

        // stage inputs
        if (s == 0)
        begin : g_first
            always_comb
            begin
                lat_in.x  = GAIN;
                lat_in.y  = '0;
                lat_in.z  = in_item.z_lat;
                lon_in.x  = GAIN;
                lon_in.y  = '0;
                lon_in.z  = in_item.z_lon;
                nlat_in   = in_item.neg_lat;
                nlon_in   = in_item.neg_lon;
                radius_in = in_item.radius;
                valid_in  = in_valid;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                lat_in    = lat_reg[s-1];
                lon_in    = lon_reg[s-1];
                nlat_in   = nlat_reg[s-1];
                nlon_in   = nlon_reg[s-1];
                radius_in = radius_reg[s-1];
                valid_in  = valid_reg[s-1];
            end
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[s] <= valid_in;
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lat_reg[s]    <= rotate(lat_in, s, ATAN);
                lon_reg[s]    <= rotate(lon_in, s, ATAN);
                nlat_reg[s]   <= nlat_in;
                nlon_reg[s]   <= nlon_in;
                radius_reg[s] <= radius_in;
            end
        end
    end

    // sign fix for folded angles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_reg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_item_reg.sin_lat <= nlat_reg[CORDIC_STEPS-1] ? -lat_reg[CORDIC_STEPS-1].y
                                                             :  lat_reg[CORDIC_STEPS-1].y;
            out_item_reg.cos_lat <= nlat_reg[CORDIC_STEPS-1] ? -lat_reg[CORDIC_STEPS-1].x
                                                             :  lat_reg[CORDIC_STEPS-1].x;
            out_item_reg.sin_lon <= nlon_reg[CORDIC_STEPS-1] ? -lon_reg[CORDIC_STEPS-1].y
                                                             :  lon_reg[CORDIC_STEPS-1].y;
            out_item_reg.cos_lon <= nlon_reg[CORDIC_STEPS-1] ? -lon_reg[CORDIC_STEPS-1].x
                                                             :  lon_reg[CORDIC_STEPS-1].x;
            out_item_reg.radius  <= radius_reg[CORDIC_STEPS-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### rtl/core/llagp_product.sv
// ----------------------------------------------------------------------------
// llagp_product
// Radius times trig products, rescale with rounding and saturation.
// ----------------------------------------------------------------------------
module llagp_product
    import llagp_pkg::*;
#(
    parameter int RESULT_FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       in_valid,
    input  trig_item_t in_item,
    output logic       out_valid,
    output point_t     out_point
);

    localparam int P1_W    = R_W + TRIG_W;    // r * trig
    localparam int RC_W    = 34;              // r*cos(lat) in Q24
    localparam int P2_W    = RC_W + TRIG_W;   // rc * trig
    localparam int RC_LSB  = 22;
    localparam int X_SHIFT = 54 - RESULT_FRAC_BITS;
    localparam int Y_SHIFT = 46 - RESULT_FRAC_BITS;
    localparam logic signed [P2_W-1:0] X_ROUND = P2_W'(1) <<< (X_SHIFT - 1);
    localparam logic signed [P1_W-1:0] Y_ROUND = P1_W'(1) <<< (Y_SHIFT - 1);
    localparam logic signed [P2_W-1:0] SAT_MAX = P2_W'((64'd1 << (POINT_W - 1)) - 64'd1);
    localparam logic signed [P2_W-1:0] SAT_MIN = -(P2_W'(1) <<< (POINT_W - 1));

    function automatic logic signed [POINT_W-1:0] sat(input logic signed [P2_W-1:0] v);
        logic signed [POINT_W-1:0] r;
        priority if (v > SAT_MAX)
        begin
            r = SAT_MAX[POINT_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[POINT_W-1:0];
        end
        else
        begin
            r = v[POINT_W-1:0];
        end
        return r;
    endfunction

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic signed [P1_W-1:0]     prc1_reg;
    logic signed [P1_W-1:0]     py1_reg;
    logic signed [TRIG_W-1:0]   so1_reg;
    logic signed [TRIG_W-1:0]   co1_reg;
    logic signed [P2_W-1:0]     px2_reg;
    logic signed [P2_W-1:0]     pz2_reg;
    logic signed [P1_W-1:0]     py2_reg;
    point_t                     point3_reg;

    logic signed [RC_W-1:0]     rc;
    logic signed [P2_W-1:0]     px_sh;
    logic signed [P2_W-1:0]     pz_sh;
    logic signed [P1_W-1:0]     py_sh;

    // r*cos(lat) to Q24 by floor
    assign rc = $signed(prc1_reg[RC_LSB+RC_W-1:RC_LSB]);

    // round half up, then rescale
    always_comb
    begin
        px_sh = (px2_reg + X_ROUND) >>> X_SHIFT;
        pz_sh = (pz2_reg + X_ROUND) >>> X_SHIFT;
        py_sh = (py2_reg + Y_ROUND) >>> Y_SHIFT;
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // product and output stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prc1_reg <= in_item.radius * in_item.cos_lat;
            py1_reg  <= in_item.radius * in_item.sin_lat;
            so1_reg  <= in_item.sin_lon;
            co1_reg  <= in_item.cos_lon;

            px2_reg  <= rc * so1_reg;
            pz2_reg  <= rc * co1_reg;
            py2_reg  <= py1_reg;

            point3_reg.x <= sat(px_sh);
            point3_reg.y <= sat({{(P2_W - P1_W){py_sh[P1_W-1]}}, py_sh});
            point3_reg.z <= sat(pz_sh);
        end
    end

    assign out_valid = v3_reg;
    assign out_point = point3_reg;

endmodule

### rtl/core/lat_lon_alt_to_globe_point.sv
// ----------------------------------------------------------------------------
// lat_lon_alt_to_globe_point
// Converts latitude, longitude and altitude to a point on a sphere.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one request per point, latitude and longitude in
//   degrees with 8 fraction bits, altitude in meters. Output stream m_*:
//   X, Y, Z with RESULT_FRAC_BITS fraction bits, saturated to 26 bits.
//   cfg_*: write of the sphere radius (Q8.16); always ready, meant to be
//   written while no request is in flight.
//   Pipeline: the front stages, then the two-lane CORDIC with one step
//   per stage and its sign fix, then the product stages and the output
//   register.
//   Throughput: one request per cycle while the skid register is empty.
//   Reset: all valid bits clear, the pipeline is empty and the radius
//   returns to 10.0.
//   Stall: while m_tready is low the pipeline keeps moving until one more
//   result lands in a skid register; then s_tready drops and the whole
//   pipeline holds until the receiver takes the output.
// ----------------------------------------------------------------------------
module lat_lon_alt_to_globe_point
    import llagp_pkg::*;
#(
    parameter int CORDIC_STEPS     = 16,
    parameter int RESULT_FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // s_tdata: latitude [15:0], longitude [32:16], altitude [48:33], zero pad
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // m_tdata: point_x [25:0], point_y [51:26], point_z [77:52], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // cfg_data: sphere_radius
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [RADIUS_W-1:0]    cfg_data
);

    logic [RADIUS_W-1:0] radius_reg;

    logic        adv;
    logic        front_valid;
    angle_item_t front_item;
    logic        trig_valid;
    trig_item_t  trig_item;
    logic        pipe_valid;
    point_t      pipe_point;

    logic        out_valid_reg;
    logic        out_valid_next;
    point_t      out_point_reg;
    point_t      out_point_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    point_t      skid_point_reg;
    point_t      skid_point_next;

    // radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 24'd655360;
        end
        else if (cfg_valid)
        begin
            radius_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // pipeline moves while the skid register is empty
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    llagp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (s_tvalid),
        .latitude      ($signed(s_tdata[15:0])),
        .longitude     ($signed(s_tdata[32:16])),
        .altitude      ($signed(s_tdata[48:33])),
        .sphere_radius (radius_reg),
        .out_valid     (front_valid),
        .out_item      (front_item)
    );

    llagp_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (trig_valid),
        .out_item  (trig_item)
    );

    llagp_product #(
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (trig_valid),
        .in_item   (trig_item),
        .out_valid (pipe_valid),
        .out_point (pipe_point)
    );

    // output register and skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_point_next  = out_point_reg;
        skid_valid_next = skid_valid_reg;
        skid_point_next = skid_point_reg;
        priority if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_point_next  = skid_point_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (pipe_valid)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_point_next = pipe_point;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_point_next = pipe_point;
                out_valid_next = 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_point_reg  <= out_point_next;
        skid_point_reg <= skid_point_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 3 * POINT_W){1'b0}},
                       out_point_reg.z, out_point_reg.y, out_point_reg.x};

endmodule

### rtl/core/llagp_checker.sv
// ----------------------------------------------------------------------------
// llagp_checker
// Port-level checks of the stream handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module llagp_checker
    import llagp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // input back-pressure only with a result waiting
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no result waiting");

    // back-pressure begins only after a stalled output
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("s_tready fell without an output stall");

    // back-pressure lasts while the receiver stalls
    a_ready_stay: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !m_tready |=> !s_tready)
        else $error("s_tready rose while receiver stalled");

endmodule

bind lat_lon_alt_to_globe_point llagp_checker u_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the lat/lon/alt to globe point converter. Directed corner
// points and random points go in through the input stream under several
// sphere radius settings. Each accepted request is predicted bit for bit by
// a CORDIC model kept here and checked against the output stream in order.
// ----------------------------------------------------------------------------
module tb_top;
    import llagp_pkg::*;

    localparam int  STEPS       = 16;
    localparam int  FRAC_BITS   = 16;
    localparam int  X_SHIFT     = 54 - FRAC_BITS;
    localparam int  Y_SHIFT     = 46 - FRAC_BITS;
    localparam int  SETTLE      = 40;    // a bit over the pipeline latency
    localparam int  HOLD_CYCLES = 400;
    localparam int  QUIET_LIMIT = 3000;
    localparam int  MAX_REPORTS = 30;
    localparam logic [RADIUS_W-1:0] RADIUS_AT_RESET = 24'd655360;
    localparam longint DEG_ONE  = longint'(1) << 24;
    localparam longint COORD_MAX = (longint'(1) << (POINT_W - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) << (POINT_W - 1));
    // angles in degrees * 256 that sit on or next to a fold or a wrap
    localparam int EDGE_ANGLES [12] = '{0, 1, -1, 23040, -23040, 23039, 23041,
                                        -23041, 46080, -46080, 46079, -46081};

    typedef logic [63:0] u64_t;

    // one input request, packed in tdata order from bit 0 up
    typedef struct packed {
        logic signed [ALT_W-1:0] alt;
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
    } point_req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [RADIUS_W-1:0]   cfg_data;

    point_req_t    pending_points [$];
    point_t        expected_points [$];
    longint        atan_q24_tab [STEPS];
    longint        gain_q30;
    logic [RADIUS_W-1:0] radius_model;

    logic          in_taken;
    logic          steady_flow = 1'b0;
    int            hold_asked = 0;
    int            hold_seen = 0;
    int            hold_left = 0;
    int            quiet_cycles;
    int            fail_count = 0;
    int            points_in = 0;
    int            points_checked = 0;
    int            stalled_cycles = 0;
    int            radius_settings = 1;

    wire in_fire  = s_tvalid && s_tready;
    wire out_fire = m_tvalid && m_tready;
    wire cfg_fire = cfg_valid && cfg_ready;

    lat_lon_alt_to_globe_point #(
        .CORDIC_STEPS     (STEPS),
        .RESULT_FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // arctangent table in Q24 degrees and inverse rotator gain in Q30
    function automatic void build_cordic_tables();
        u64_t acc;
        u64_t rem;
        u64_t quo;
        u64_t g2;
        u64_t v;
        u64_t root;
        u64_t bitv;
        int   i;
        int   k;
        int   e;
        g2 = u64_t'(1) << 60;
        for (i = 0; i < STEPS; i++)
        begin
            if (i == 0)
            begin
                atan_q24_tab[0] = 45 * DEG_ONE;
            end
            else
            begin
                // atan(2^-i) in Q62 by its power series
                acc = '0;
                k   = 0;
                e   = 62 - i;
                while (e >= 0)
                begin
                    if (k % 2 == 1)
                    begin
                        acc = acc - (u64_t'(1) << e) / u64_t'(2 * k + 1);
                    end
                    else
                    begin
                        acc = acc + (u64_t'(1) << e) / u64_t'(2 * k + 1);
                    end
                    k = k + 1;
                    e = 62 - i * (2 * k + 1);
                end
                // divide by pi bit by bit, then scale by 180 into Q24
                rem = acc;
                quo = '0;
                repeat (40)
                begin
                    rem = rem << 1;
                    quo = quo << 1;
                    if (rem >= PI_Q60)
                    begin
                        rem = rem - PI_Q60;
                        quo = quo | u64_t'(1);
                    end
                end
                atan_q24_tab[i] = longint'((u64_t'(45) * quo + (u64_t'(1) << 15)) >> 16);
            end
            if (2 * i < 61)
            begin
                g2 = g2 + (g2 >> (2 * i));
            end
        end
        // integer square root of the squared gain
        v    = g2;
        root = '0;
        bitv = u64_t'(1) << 62;
        while (bitv > v)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        gain_q30 = longint'(((u64_t'(1) << 60) + (root >> 1)) / root);
    endfunction

    // sine and cosine in Q30 of a Q24 degree angle
    function automatic void cordic_sin_cos(input longint ang, output longint sin_q30,
                                           output longint cos_q30);
        longint x;
        longint y;
        longint t;
        bit     flip;
        int     i;
        x    = gain_q30;
        y    = 0;
        flip = 1'b0;
        // wrap into [-180,180), then fold into [-90,90]
        if (ang >= 180 * DEG_ONE)
        begin
            ang = ang - 360 * DEG_ONE;
        end
        if (ang < -180 * DEG_ONE)
        begin
            ang = ang + 360 * DEG_ONE;
        end
        if (ang > 90 * DEG_ONE)
        begin
            ang  = ang - 180 * DEG_ONE;
            flip = 1'b1;
        end
        else if (ang < -90 * DEG_ONE)
        begin
            ang  = ang + 180 * DEG_ONE;
            flip = 1'b1;
        end
        for (i = 0; i < STEPS; i++)
        begin
            if (ang >= 0)
            begin
                t   = x - (y >>> i);
                y   = y + (x >>> i);
                x   = t;
                ang = ang - atan_q24_tab[i];
            end
            else
            begin
                t   = x + (y >>> i);
                y   = y - (x >>> i);
                x   = t;
                ang = ang + atan_q24_tab[i];
            end
        end
        sin_q30 = flip ? -y : y;
        cos_q30 = flip ? -x : x;
    endfunction

    function automatic logic [POINT_W-1:0] clamp_coord(input longint v);
        if (v > COORD_MAX)
        begin
            v = COORD_MAX;
        end
        if (v < COORD_MIN)
        begin
            v = COORD_MIN;
        end
        return v[POINT_W-1:0];
    endfunction

    // expected point for one request under a given radius
    function automatic point_t predict_globe_point(input point_req_t req,
                                                   input logic [RADIUS_W-1:0] radius);
        longint n;
        longint adj;
        longint r;
        longint s_lat;
        longint c_lat;
        longint s_lon;
        longint c_lon;
        longint rc;
        point_t p;
        // altitude term rounded half away from zero
        n = longint'($signed(req.alt)) * 65536;
        if (n >= 0)
        begin
            adj = (n + 137500) / 275000;
        end
        else
        begin
            adj = -((-n + 137500) / 275000);
        end
        r = longint'({40'd0, radius}) + adj;
        cordic_sin_cos(longint'($signed(req.lat)) * 65536, s_lat, c_lat);
        cordic_sin_cos(longint'($signed(req.lon)) * 65536, s_lon, c_lon);
        rc  = (r * c_lat) >>> 22;
        p.x = clamp_coord((rc * s_lon + (longint'(1) << (X_SHIFT - 1))) >>> X_SHIFT);
        p.y = clamp_coord((r * s_lat + (longint'(1) << (Y_SHIFT - 1))) >>> Y_SHIFT);
        p.z = clamp_coord((rc * c_lon + (longint'(1) << (X_SHIFT - 1))) >>> X_SHIFT);
        return p;
    endfunction

    function automatic void check_coord(input string name, input logic [POINT_W-1:0] want,
                                        input logic [POINT_W-1:0] got);
        if (want !== got)
        begin
            fail_count = fail_count + 1;
            if (fail_count <= MAX_REPORTS)
            begin
                $display("%0t %s mismatch: expected %0d actual %0d",
                         $time, name, $signed(want), $signed(got));
            end
        end
    endfunction

    function automatic point_req_t random_point_req();
        point_req_t req;
        int         mode;
        mode    = $urandom_range(0, 99);
        req.alt = ALT_W'($urandom);
        if (mode < 45)
        begin
            // any bit pattern, angles past the nominal range included
            req.lat = LAT_W'($urandom);
            req.lon = LON_W'($urandom);
        end
        else if (mode < 85)
        begin
            req.lat = LAT_W'(int'($urandom_range(0, 46080)) - 23040);
            req.lon = LON_W'(int'($urandom_range(0, 92160)) - 46080);
        end
        else
        begin
            req.lat = LAT_W'(EDGE_ANGLES[$urandom_range(0, 11)]);
            req.lon = LON_W'(EDGE_ANGLES[$urandom_range(0, 11)]);
            if ($urandom_range(0, 1) == 1)
            begin
                req.alt = ALT_W'(int'($urandom_range(0, 200)) - 100);
            end
        end
        return req;
    endfunction

    task automatic add_point(input int lat, input int lon, input int alt);
        point_req_t req;
        req.lat = LAT_W'(lat);
        req.lon = LON_W'(lon);
        req.alt = ALT_W'(alt);
        pending_points.push_back(req);
    endtask

    task automatic add_random_points(input int count);
        repeat (count)
        begin
            pending_points.push_back(random_point_req());
        end
    endtask

    // wait until every request went in and every point came back
    task automatic wait_drained();
        while (pending_points.size() != 0 || s_tvalid || expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        radius_settings = radius_settings + 1;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // request driver, changes on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (pending_points.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 20))
            begin
                s_tdata  <= IN_DATA_W'(pending_points.pop_front());
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and long hold-offs on demand
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= steady_flow || ($urandom_range(0, 99) >= 20);
        end
    end

    // monitor: predict on input acceptance, check on output acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken     <= 1'b0;
            radius_model <= RADIUS_AT_RESET;
        end
        else
        begin
            in_taken <= in_fire;
            if (cfg_fire)
            begin
                radius_model <= cfg_data;
            end
            if (s_tvalid && !s_tready)
            begin
                stalled_cycles <= stalled_cycles + 1;
            end
            if (in_fire)
            begin
                expected_points.push_back(predict_globe_point(
                    point_req_t'(s_tdata[$bits(point_req_t)-1:0]), radius_model));
                points_in <= points_in + 1;
            end
            if (out_fire)
            begin
                if (expected_points.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t unexpected point: expected none actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    check_coord("point_x", expected_points[0].x, m_tdata[25:0]);
                    check_coord("point_y", expected_points[0].y, m_tdata[51:26]);
                    check_coord("point_z", expected_points[0].z, m_tdata[77:52]);
                    void'(expected_points.pop_front());
                    points_checked <= points_checked + 1;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n || in_fire || out_fire || cfg_fire)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t timeout: no transfer for %0d cycles, %0d points outstanding",
                         $time, quiet_cycles, expected_points.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        build_cordic_tables();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner points under the reset radius
        add_point(0, 0, 0);
        add_point(23040, 0, 0);
        add_point(-23040, 0, 0);
        add_point(0, 23040, 0);
        add_point(0, -23040, 0);
        add_point(0, 46080, 0);
        add_point(0, -46080, 0);
        add_point(23041, 0, 0);
        add_point(-23041, 0, 0);
        add_point(0, 23041, 100);
        add_point(0, -23041, -100);
        add_point(0, 46079, 0);
        add_point(0, -46081, 0);
        add_point(32767, 65535, 32767);
        add_point(-32768, -65536, -32768);
        add_point(11520, 11520, 1);
        add_point(-11520, -11520, -1);
        add_point(23040, 46080, 32767);
        add_point(-23040, -46080, -32768);
        add_point(21845, -43691, 21845);
        add_point(-21846, 43690, -21846);
        add_point(256, 256, 0);
        add_random_points(250);
        wait_drained();

        // zero radius: the altitude term alone, negative radius included
        write_radius('0);
        add_random_points(200);
        wait_drained();

        // largest radius, no idling, then a long receiver hold-off
        write_radius('1);
        steady_flow = 1'b1;
        add_random_points(300);
        hold_asked = hold_asked + 1;
        wait_drained();
        steady_flow = 1'b0;

        write_radius(24'd1);
        add_random_points(150);
        wait_drained();

        write_radius(RADIUS_W'($urandom));
        add_random_points(250);
        wait_drained();

        write_radius(24'h800000);
        add_random_points(200);
        wait_drained();

        write_radius(RADIUS_W'($urandom_range(0, 24'h1FFFFF)));
        add_random_points(400);
        wait_drained();

        if (expected_points.size() != 0)
        begin
            fail_count = fail_count + 1;
            $display("%0t missing points: expected %0d more actual 0",
                     $time, expected_points.size());
        end
        $display("run covered %0d points under %0d radius settings, %0d checked",
                 points_in, radius_settings, points_checked);
        $display("input held back %0d cycles, %0d mismatches", stalled_cycles, fail_count);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
